### design/swrm_pkg.sv
`default_nettype none
package swrm_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int FRAC_DEF  = 8;
  localparam int TS_W      = 64;
  localparam int RATE_W    = 32;
  localparam int ENTRY_W   = 7;
  localparam int WMS_W     = 16;
  localparam int WIN_W     = 36;   // window_ms * 1e6 fits in 36 bits
  localparam int NUM_W     = 62;   // 32-bit count times 1e9

  localparam logic [WMS_W-1:0] WMS_RESET    = 16'd1000;
  localparam logic [29:0]      NS_PER_S     = 30'd1000000000;
  localparam logic [19:0]      NS_PER_MS    = 20'd1000000;
  localparam logic [9:0]       ONE_PAIR_NUM = 10'd1000;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TOCK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  typedef enum logic [1:0] {DIV_ONE, DIV_WIN, DIV_TOT} div_sel_t;
  typedef enum logic {MUL_WIN, MUL_TOT} mul_sel_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [TS_W-1:0] now_ns;
  } swrm_in_t;

  typedef struct packed {
    logic [RATE_W-1:0]  window_rate;
    logic [RATE_W-1:0]  total_rate;
    logic [RATE_W-1:0]  completed_jobs;
    logic [ENTRY_W-1:0] entries_held;
    logic               overflowed;
  } swrm_out_t;

  typedef struct packed {
    logic     load_item;
    logic     clear;
    logic     calc_win;
    logic     calc_lim;
    logic     end_wr;
    logic     push;
    logic     ev_rd;
    logic     evict;
    logic     cap_first;
    logic     rd_last;
    logic     cap_last;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     wrate_zero;
    logic     wrate_div;
    logic     trate_zero;
    logic     trate_div;
    logic     out_load;
  } swrm_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic last_open;
    logic evict_ok;
    logic last_lt_first;
    logic total_zero;
    logic div_done;
  } swrm_stat_t;

endpackage
`default_nettype wire

### design/sliding_window_rate_meter.sv
// Sliding-window job rate meter.
// Input channel (in_valid/in_stall/in_data): op is tick (job start), tock (job
// end), restart or none, with a nanosecond timestamp. Output channel
// (out_valid/out_stall/out_data): one result per item with the window rate
// and lifetime rate (unsigned fixed point, FRAC_BITS fraction bits,
// saturating), completed jobs, pairs held and the overflow flag.
// cfg_we/cfg_data write window_ms; the user must do so only while the block
// is idle, a rule the block itself does not enforce. One item at a time. For
// tick and tock the bit-serial divider runs at most once for each rate, in
// 62 + FRAC_BITS steps, and the eviction walk reads one pair at a time from
// the RAMs.
// The result sits in an output register; while it is stalled the block
// still takes and works on the next item, then waits to hand it over.
// Reset: window 1000 ms, empty FIFO, counters and rates zero, origin time 0.
`default_nettype none
module sliding_window_rate_meter import swrm_pkg::*; #(
  parameter int FIFO_DEPTH = DEPTH_DEF,
  parameter int FRAC_BITS  = FRAC_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire swrm_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output swrm_out_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [WMS_W-1:0] cfg_data
);

  swrm_cmd_t  cmd;
  swrm_stat_t stat;

  swrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  swrm_dp #(.FIFO_DEPTH(FIFO_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took an item without going busy");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled result");

  a_div_start_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !stat.div_done)
    else $error("divider reported done right after start");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.push || cmd.evict |-> in_stall)
    else $error("FIFO changed while input was open");

endmodule
`default_nettype wire

### design/swrm_ram.sv
`default_nettype none
module swrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/swrm_div.sv
`default_nettype none
module swrm_div import swrm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [TS_W-1:0]   den,
  output logic                   done,
  output logic [RATE_W-1:0]      quo
);

  localparam int DW = NUM_W + FRAC_BITS;
  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0]     dvd;
  logic [TS_W-1:0]   rem;
  logic [TS_W-1:0]   dsr;
  logic [RATE_W-1:0] q;
  logic              ovf;
  logic              busy;
  logic [KW-1:0]     cnt;
  logic [TS_W:0]     trial;
  logic              ge;

  assign trial = {rem, dvd[DW-1]};
  assign ge    = trial >= {1'b0, dsr};
  // any quotient bit past bit 31 saturates the result
  assign quo   = ovf ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= DW'(num) << FRAC_BITS;
        dsr  <= den;
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        cnt  <= KW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        dvd <= dvd << 1;
        rem <= ge ? TS_W'(trial - {1'b0, dsr}) : trial[TS_W-1:0];
        q   <= {q[RATE_W-2:0], ge};
        ovf <= ovf | q[RATE_W-1];
        cnt <= cnt - 1'b1;
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/swrm_dp.sv
`default_nettype none
module swrm_dp import swrm_pkg::*; #(
  parameter int FIFO_DEPTH = DEPTH_DEF,
  parameter int FRAC_BITS  = FRAC_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire swrm_in_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic [WMS_W-1:0] cfg_data,
  input  wire swrm_cmd_t        cmd,
  output swrm_stat_t            stat,
  output swrm_out_t             out_data
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [WMS_W-1:0]  window_ms;
  logic [TS_W-1:0]   now_q;
  logic [WIN_W-1:0]  win;
  logic [TS_W-1:0]   lim;
  logic              lim_ok;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic              last_open;
  logic [RATE_W-1:0] job_starts;
  logic [RATE_W-1:0] done_count;
  logic [TS_W-1:0]   origin;
  logic [TS_W-1:0]   first;
  logic [TS_W-1:0]   last;
  logic [NUM_W-1:0]  prod;
  logic [RATE_W-1:0] wrate;
  logic [RATE_W-1:0] trate;
  logic              ovf;

  logic [AW-1:0]     push_addr;
  logic [AW-1:0]     newest;
  logic [AW-1:0]     head_inc;
  logic [TS_W-1:0]   start_rd;
  logic [TS_W-1:0]   end_rd;
  logic [AW-1:0]     rd_addr;
  logic [RATE_W-1:0] mul_a;
  logic [NUM_W-1:0]  div_num;
  logic [TS_W-1:0]   div_den;
  logic [RATE_W-1:0] div_q;
  logic              full;

  // ring index: head + k, with k at most the depth
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(FIFO_DEPTH)) begin
      s = s - (CW+1)'(FIFO_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full      = count == CW'(FIFO_DEPTH);
  // when full this lands on head, the slot freed by dropping the oldest
  assign push_addr = slot(head, count);
  assign newest    = slot(head, count - 1'b1);
  assign head_inc  = slot(head, CW'(1));
  assign rd_addr   = cmd.rd_last ? newest : head;

  swrm_ram #(.WIDTH(TS_W), .DEPTH(FIFO_DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (push_addr),
    .wdata (now_q),
    .re    (cmd.ev_rd | cmd.rd_last),
    .raddr (rd_addr),
    .rdata (start_rd)
  );

  swrm_ram #(.WIDTH(TS_W), .DEPTH(FIFO_DEPTH)) u_end_ram (
    .clk   (clk),
    .we    (cmd.push | cmd.end_wr),
    .waddr (cmd.end_wr ? newest : push_addr),
    .wdata (cmd.end_wr ? now_q : '0),
    .re    (cmd.ev_rd),
    .raddr (head),
    .rdata (end_rd)
  );

  always_comb begin
    mul_a = (cmd.mul_sel == MUL_TOT) ? job_starts - 1'b1 : RATE_W'(count) - 1'b1;
    case (cmd.div_sel)
      DIV_WIN: begin
        div_num = prod;
        div_den = last - first;
      end
      DIV_TOT: begin
        div_num = prod;
        div_den = last - origin;
      end
      default: begin
        div_num = NUM_W'(ONE_PAIR_NUM);
        div_den = TS_W'(window_ms);
      end
    endcase
  end

  swrm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (stat.div_done),
    .quo   (div_q)
  );

  // a closed pair that ended before now minus the window leaves the front
  assign stat.evict_ok      = (end_rd > start_rd) && lim_ok && (end_rd < lim);
  assign stat.cnt_zero      = count == '0;
  assign stat.cnt_one       = count == CW'(1);
  assign stat.last_open     = last_open;
  assign stat.last_lt_first = last < first;
  assign stat.total_zero    = (job_starts == '0) || (last < origin);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms  <= WMS_RESET;
      head       <= '0;
      count      <= '0;
      last_open  <= 1'b0;
      job_starts <= '0;
      done_count <= '0;
      origin     <= '0;
      wrate      <= '0;
      trate      <= '0;
    end else begin
      if (cfg_we) begin
        window_ms <= cfg_data;
      end
      if (cmd.load_item) begin
        now_q <= in_data.now_ns;
        ovf   <= 1'b0;
      end
      if (cmd.clear) begin
        head       <= '0;
        count      <= '0;
        last_open  <= 1'b0;
        job_starts <= '0;
        done_count <= '0;
        origin     <= in_data.now_ns;
        wrate      <= '0;
        trate      <= '0;
      end
      if (cmd.calc_win) begin
        win <= WIN_W'(window_ms) * WIN_W'(NS_PER_MS);
      end
      if (cmd.calc_lim) begin
        lim_ok <= now_q >= TS_W'(win);
        lim    <= now_q - TS_W'(win);
      end
      if (cmd.end_wr) begin
        last_open  <= 1'b0;
        done_count <= done_count + 1'b1;
      end
      if (cmd.push) begin
        if (full) begin
          head <= head_inc;
          ovf  <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
        last_open  <= 1'b1;
        job_starts <= job_starts + 1'b1;
      end
      if (cmd.evict) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
      if (cmd.cap_first) begin
        first <= start_rd;
      end
      if (cmd.cap_last) begin
        last <= start_rd;
      end
      if (cmd.mul_go) begin
        prod <= NUM_W'(mul_a) * NUM_W'(NS_PER_S);
      end
      if (cmd.wrate_zero) begin
        wrate <= '0;
      end
      if (cmd.wrate_div) begin
        wrate <= div_q;
      end
      if (cmd.trate_zero) begin
        trate <= '0;
      end
      if (cmd.trate_div) begin
        trate <= div_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.window_rate    <= wrate;
      out_data.total_rate     <= trate;
      out_data.completed_jobs <= done_count;
      out_data.entries_held   <= ENTRY_W'(count);
      out_data.overflowed     <= ovf;
    end
  end

endmodule
`default_nettype wire

### design/swrm_ctrl.sv
`default_nettype none
module swrm_ctrl import swrm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire swrm_stat_t stat,
  output swrm_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_LIM, S_END, S_PUSH, S_EVRD, S_EVCHK, S_LAST,
    S_WMUL, S_WDS, S_WDIV, S_TMUL, S_TDS, S_TDIV, S_OUT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] op;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (in_op == OP_RESTART) begin
            cmd.clear  = 1'b1;
            state_next = S_OUT;
          end else if (in_op == OP_NONE) begin
            state_next = S_OUT;
          end else begin
            state_next = S_WIN;
          end
        end
      end
      S_WIN: begin
        cmd.calc_win = 1'b1;
        state_next   = S_LIM;
      end
      S_LIM: begin
        cmd.calc_lim = 1'b1;
        if (op == OP_TICK) begin
          state_next = stat.last_open ? S_END : S_PUSH;
        end else begin
          state_next = stat.cnt_zero ? S_EVRD : S_END;
        end
      end
      S_END: begin
        cmd.end_wr = 1'b1;
        state_next = (op == OP_TICK) ? S_PUSH : S_EVRD;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_EVRD;
      end
      S_EVRD: begin
        if (stat.cnt_zero) begin
          cmd.wrate_zero = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.ev_rd  = 1'b1;
          state_next = S_EVCHK;
        end
      end
      S_EVCHK: begin
        if (stat.evict_ok) begin
          cmd.evict  = 1'b1;
          state_next = S_EVRD;
        end else begin
          // the front start time is already on the read port
          cmd.cap_first = 1'b1;
          cmd.rd_last   = 1'b1;
          state_next    = S_LAST;
        end
      end
      S_LAST: begin
        cmd.cap_last = 1'b1;
        state_next   = S_WMUL;
      end
      S_WMUL: begin
        if (stat.cnt_one) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_ONE;
          state_next    = S_WDIV;
        end else if (stat.last_lt_first) begin
          cmd.wrate_zero = 1'b1;
          state_next     = S_TMUL;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MUL_WIN;
          state_next  = S_WDS;
        end
      end
      S_WDS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_WIN;
        state_next    = S_WDIV;
      end
      S_WDIV: begin
        if (stat.div_done) begin
          cmd.wrate_div = 1'b1;
          state_next    = S_TMUL;
        end
      end
      S_TMUL: begin
        if (stat.total_zero) begin
          cmd.trate_zero = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MUL_TOT;
          state_next  = S_TDS;
        end
      end
      S_TDS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TOT;
        state_next    = S_TDIV;
      end
      S_TDIV: begin
        if (stat.div_done) begin
          cmd.trate_div = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_item) begin
        op <= in_op;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### tb/sliding_window_rate_meter_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module sliding_window_rate_meter_tb;
  import swrm_pkg::*;

  localparam int          DEPTH    = DEPTH_DEF;
  localparam int          FRAC     = FRAC_DEF;
  localparam int          IDLE_MAX = 5000;
  localparam logic [31:0] SAT      = 32'hFFFF_FFFF;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  swrm_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  swrm_out_t        out_data;
  logic             cfg_we;
  logic [WMS_W-1:0] cfg_data;

  sliding_window_rate_meter #(.FIFO_DEPTH(DEPTH), .FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // meter model state
  logic [63:0] m_start [DEPTH];
  logic [63:0] m_end [DEPTH];
  int          m_head;
  int          m_count;
  logic        m_open;
  logic [31:0] m_starts;
  logic [31:0] m_done;
  logic [63:0] m_origin;
  logic [31:0] m_wrate;
  logic [31:0] m_trate;
  logic [15:0] m_window;

  swrm_out_t   rate_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          overflows_seen = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic [63:0] cur_ns = 0;

  function automatic logic [31:0] fixed_quot(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    logic        top;
    if (den == 0) return SAT;
    q = num / den;
    rem = num % den;
    if ((q >> (32 - FRAC)) != 0) return SAT;
    for (int b = 0; b < FRAC; b++) begin
      top = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (top || rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q[31:0];
  endfunction

  function automatic int slot(int k);
    return (m_head + k) % DEPTH;
  endfunction

  task automatic model_clear(logic [63:0] now);
    m_head = 0;
    m_count = 0;
    m_open = 1'b0;
    m_starts = 0;
    m_done = 0;
    m_origin = now;
    m_wrate = 0;
    m_trate = 0;
  endtask

  task automatic model_close_newest(logic [63:0] now);
    if (m_count == 0) return;
    m_open = 1'b0;
    m_done++;
    m_end[slot(m_count - 1)] = now;
  endtask

  task automatic model_rates(logic [63:0] now);
    logic [63:0] win;
    logic [63:0] first;
    logic [63:0] last;
    int          h;
    win = 64'(m_window) * 64'd1000000;
    while (m_count > 0) begin
      h = slot(0);
      if (!(m_end[h] > m_start[h])) break;
      if (now < win || !(m_end[h] < now - win)) break;
      m_head = slot(1);
      m_count--;
    end
    if (m_count == 0) begin
      m_wrate = 0;
      return;
    end
    first = m_start[slot(0)];
    last = m_start[slot(m_count - 1)];
    if (m_count == 1) m_wrate = fixed_quot(64'd1000, 64'(m_window));
    else if (last < first) m_wrate = 0;
    else m_wrate = fixed_quot(64'(m_count - 1) * 64'd1000000000, last - first);
    if (m_starts == 0 || last < m_origin) m_trate = 0;
    else m_trate = fixed_quot(64'(m_starts - 1) * 64'd1000000000, last - m_origin);
  endtask

  task automatic predict_rates(swrm_in_t it, output swrm_out_t r);
    logic ovf;
    ovf = 1'b0;
    case (it.op)
      OP_TICK: begin
        if (m_open) model_close_newest(it.now_ns);
        if (m_count >= DEPTH) begin
          m_head = slot(1);
          m_count = DEPTH - 1;
          ovf = 1'b1;
        end
        m_start[slot(m_count)] = it.now_ns;
        m_end[slot(m_count)] = 0;
        m_count++;
        m_open = 1'b1;
        m_starts++;
        model_rates(it.now_ns);
      end
      OP_TOCK: begin
        model_close_newest(it.now_ns);
        model_rates(it.now_ns);
      end
      OP_RESTART: model_clear(it.now_ns);
      default: ;
    endcase
    r.window_rate = m_wrate;
    r.total_rate = m_trate;
    r.completed_jobs = m_done;
    r.entries_held = ENTRY_W'(m_count);
    r.overflowed = ovf;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, results_seen);
  endtask

  // sender: bursts with random gaps; valid stays up between items of a burst
  task automatic send_item(logic [1:0] op, logic [63:0] now);
    swrm_in_t  it;
    swrm_out_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    it.op = op;
    it.now_ns = now;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    predict_rates(it, r);
    rate_q.push_back(r);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic drain();
    release_input();
    while (rate_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(logic [15:0] ms);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_window = ms;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (rate_q.size() == 0) begin
        report("unexpected result", 64'(out_data.window_rate), 64'd0);
      end else begin
        if (out_data.window_rate !== rate_q[0].window_rate)
          report("window_rate", out_data.window_rate, rate_q[0].window_rate);
        if (out_data.total_rate !== rate_q[0].total_rate)
          report("total_rate", out_data.total_rate, rate_q[0].total_rate);
        if (out_data.completed_jobs !== rate_q[0].completed_jobs)
          report("completed_jobs", out_data.completed_jobs, rate_q[0].completed_jobs);
        if (out_data.entries_held !== rate_q[0].entries_held)
          report("entries_held", out_data.entries_held, rate_q[0].entries_held);
        if (out_data.overflowed !== rate_q[0].overflowed)
          report("overflowed", out_data.overflowed, rate_q[0].overflowed);
        if (out_data.overflowed === 1'b1) overflows_seen++;
        void'(rate_q.pop_front());
      end
    end
  end

  // receiver stall pattern: calm stretches and busy stretches
  int stall_phase = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(20, 400);
      stall_mode = $urandom_range(0, 3);
    end
    stall_phase--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_MAX) begin
      $display("watchdog: no progress for %0d cycles", IDLE_MAX);
      $display("sliding_window_rate_meter_tb: done, errors");
      $finish;
    end
  end

  task automatic test_defaults();
    send_item(OP_TOCK, 64'd5);
    send_item(OP_TICK, 64'd0);
    send_item(OP_TICK, 64'd0);
    send_item(OP_TOCK, 64'd100);
    send_item(OP_TOCK, 64'd200);
    send_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_corner_cases();
    send_item(OP_RESTART, 64'd4_000_000_000);
    send_item(OP_TICK, 64'd3_000_000_000);
    send_item(OP_TICK, 64'd5_000_000_000);
    send_item(OP_TICK, 64'd4_500_000_000);
    send_item(OP_TOCK, 64'd4_600_000_000);
    send_item(OP_TICK, 64'd9_000_000_000);
    send_item(OP_TOCK, 64'd9_000_000_100);
    send_item(OP_TICK, 64'd20_000_000_000);
    drain();
    send_item(OP_RESTART, 64'hFFFF_FFFF_FFFF_FFF0);
    send_item(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_TOCK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_TICK, 64'h0);
    set_window(16'd0);
    send_item(OP_RESTART, 64'd0);
    send_item(OP_TICK, 64'd10);
    send_item(OP_TOCK, 64'd20);
    send_item(OP_TICK, 64'd30);
    set_window(16'd65535);
    send_item(OP_TICK, 64'd40);
    send_item(OP_TOCK, 64'hAAAA_5555_AAAA_5555);
    send_item(OP_TICK, 64'h5555_AAAA_5555_AAAA);
  endtask

  task automatic test_fifo_overflow();
    set_window(16'd1);
    send_item(OP_RESTART, 64'd1000);
    for (int i = 0; i < DEPTH + 6; i++) send_item(OP_TICK, 64'd1000 + 64'(i) * 64'd7);
    send_item(OP_TOCK, 64'd2000);
    send_item(OP_TICK, 64'd50_000_000);
  endtask

  task automatic test_random_traffic();
    logic [15:0] ms;
    logic [63:0] span;
    int          pick;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ms = 16'd1;
        1: ms = 16'd65535;
        2: ms = 16'($urandom_range(1, 8));
        3: ms = 16'd0;
        default: ms = 16'($urandom_range(1, 65535));
      endcase
      set_window(ms);
      span = (ms == 0) ? 64'd500_000 : 64'(ms) * 64'd400_000;
      if (ph == 2) drain();
      for (int i = 0; i < 80; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          cur_ns = cur_ns + {$urandom_range(0, 3), $urandom} % span;
          send_item((pick < 45) ? OP_TICK : OP_TOCK, cur_ns);
        end else if (pick < 88) begin
          cur_ns = {$urandom, $urandom} >> $urandom_range(0, 40);
          send_item(OP_RESTART, cur_ns);
        end else if (pick < 92) begin
          send_item(OP_NONE, {$urandom, $urandom});
        end else if (pick < 96) begin
          send_item(2'($urandom_range(0, 1)), cur_ns - 64'($urandom_range(0, 5_000_000)));
        end else begin
          send_item(2'($urandom_range(0, 1)), {$urandom, $urandom});
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    out_stall <= 1'b0;
    model_clear(64'd0);
    m_window = WMS_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_corner_cases();
    test_fifo_overflow();
    test_random_traffic();
    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d items, %0d results, %0d overflow drops", items_sent,
             results_seen, overflows_seen);
    $display("windows 0, 1, 65535 ms and random; ticks, tocks, restarts, none ops");
    if (errors == 0 && rate_q.size() == 0) begin
      $display("sliding_window_rate_meter_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, rate_q.size());
      $display("sliding_window_rate_meter_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
design/swrm_pkg.sv
design/swrm_ram.sv
design/swrm_div.sv
design/swrm_dp.sv
design/swrm_ctrl.sv
design/sliding_window_rate_meter.sv
tb/sliding_window_rate_meter_tb.sv
